@@ sv/ecad_pkg.sv @@
// Package for the event code activity display: types, command codes, constants.
// No dependencies.
package ecad_pkg;
    localparam int NumCodesDefault = 127;
    localparam int CodesPerRowDefault = 10;

    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_ERASE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] REG_HOLD   = 2'd0;
    localparam logic [1:0] REG_CWIDTH = 2'd1;
    localparam logic [1:0] REG_CHEIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LINK,
        ST_RELINK,
        ST_GEOM,
        ST_OUT
    } ecad_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic read_mem;
        logic do_link;
        logic do_relink;
        logic do_geom;
        logic show_out;
    } ecad_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ignore;
        logic no_result;
        logic needs_relink;
    } ecad_status_t;
endpackage

@@ sv/ecad_ctrl.sv @@
// Controller state machine for the event code activity display.
// Depends on ecad_pkg.
module ecad_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  out_busy,
    input  ecad_pkg::ecad_status_t status,
    output ecad_pkg::ecad_cmd_t   cmd
);
    import ecad_pkg::*;

    ecad_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read_mem = 1'b1;
                state_next = ST_LINK;
            end
            ST_LINK: begin
                if (status.ignore) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.do_link = 1'b1;
                    state_next = status.needs_relink ? ST_RELINK : ST_GEOM;
                end
            end
            ST_RELINK: begin
                cmd.do_relink = 1'b1;
                state_next = ST_GEOM;
            end
            ST_GEOM: begin
                if (status.no_result) begin
                    state_next = ST_IDLE;
                end else if (!out_busy) begin
                    cmd.do_geom = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.show_out = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE) else $error("input taken outside idle");
    a_geom_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_geom |-> !out_busy) else $error("result overwrites pending item");
    a_out_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_geom |=> cmd.show_out) else $error("result not presented");
endmodule

@@ sv/ecad_dp.sv @@
// Datapath: code tables, age-ordered list, expiry test, cell geometry, output register.
// Depends on ecad_pkg.
module ecad_dp #(
    parameter int NUM_CODES = ecad_pkg::NumCodesDefault,
    parameter int CODES_PER_ROW = ecad_pkg::CodesPerRowDefault
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ecad_pkg::ecad_cmd_t   cmd,
    output ecad_pkg::ecad_status_t status,
    input  logic [1:0]            in_op,
    input  logic [7:0]            in_code,
    input  logic [31:0]           in_now,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic                  out_busy,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [1:0]            m_command,
    output logic [6:0]            m_code,
    output logic [9:0]            m_x_pos,
    output logic [9:0]            m_y_pos,
    output logic [8:0]            m_area_width,
    output logic [9:0]            m_area_height,
    output logic [1:0]            m_digit_count
);
    import ecad_pkg::*;

    localparam int IW = $clog2(NUM_CODES);
    localparam int Rows = (NUM_CODES + CODES_PER_ROW - 1) / CODES_PER_ROW;
    // rounded-up reciprocal of the row length, exact for any 8-bit code
    localparam logic [16:0] RowRecip = 17'((65536 + CODES_PER_ROW - 1) / CODES_PER_ROW);

    logic [30:0] hold_reg;
    logic [5:0]  cw_reg;
    logic [6:0]  ch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 31'd700000;
            cw_reg   <= 6'd8;
            ch_reg   <= 7'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HOLD:    hold_reg <= cfg_data[30:0];
                REG_CWIDTH:  cw_reg <= cfg_data[5:0];
                REG_CHEIGHT: ch_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // shown flags in flip-flops; time and link stores in memories
    logic [NUM_CODES-1:0] shown_reg;
    logic [31:0] time_mem [NUM_CODES];
    logic [7:0]  next_mem [NUM_CODES];
    logic [7:0]  prev_mem [NUM_CODES];

    logic [7:0] oldest_reg, newest_reg;
    logic       nonempty_reg;
    logic [1:0] op_reg;
    logic [7:0] code_reg;
    logic [31:0] now_reg;

    // read data of the item's code (event) or the oldest (tick)
    logic [31:0] rd_time_reg;
    logic [7:0]  rd_next_reg, rd_prev_reg;
    logic        was_shown_reg;
    logic [7:0]  tgt_reg;      // code reported or worked on
    logic        nores_reg;

    function automatic logic valid_code(input logic [7:0] c);
        return c != 8'd0 && {24'd0, c} <= NUM_CODES;
    endfunction

    logic [7:0]  sel_code;
    logic [IW-1:0] sel_idx;
    logic [31:0] age;
    assign sel_code = (op_reg == OP_EVENT) ? code_reg : oldest_reg;
    assign sel_idx  = IW'(sel_code - 8'd1);
    assign age = now_reg - rd_time_reg;

    logic ignore_c;
    always_comb begin
        ignore_c = 1'b1;
        case (op_reg)
            OP_EVENT: ignore_c = !valid_code(code_reg);
            OP_TICK:  ignore_c = !nonempty_reg || !valid_code(oldest_reg) || age[31]
                                 || age <= {1'b0, hold_reg};
            OP_CLEAR: ignore_c = 1'b0;
            default:  ignore_c = 1'b1;
        endcase
    end
    assign status.ignore = ignore_c;
    assign status.needs_relink = (op_reg == OP_EVENT) && was_shown_reg;
    assign status.no_result = nores_reg;

    // list pointers after the unlink of a repeated code, written by the link step
    logic [7:0] new_old_c, new_new_c;
    logic       new_ne_c;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg   <= in_op;
            code_reg <= in_code;
            now_reg  <= in_now;
        end
        if (cmd.read_mem) begin
            rd_time_reg   <= time_mem[sel_idx];
            rd_next_reg   <= next_mem[sel_idx];
            rd_prev_reg   <= prev_mem[sel_idx];
            was_shown_reg <= shown_reg[sel_idx];
        end
    end

    // unlink of a repeated code; outputs list pointers
    always_comb begin
        new_old_c = oldest_reg;
        new_new_c = newest_reg;
        new_ne_c  = nonempty_reg;
        if (valid_code(rd_next_reg)) begin
            // prev fix-up written in link step
        end else begin
            new_new_c = rd_prev_reg;
        end
        if (!valid_code(rd_prev_reg)) new_old_c = rd_next_reg;
        if (rd_prev_reg == 8'd0 && rd_next_reg == 8'd0) new_ne_c = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg    <= '0;
            oldest_reg   <= '0;
            newest_reg   <= '0;
            nonempty_reg <= 1'b0;
            nores_reg    <= 1'b0;
        end else begin
            if (cmd.do_link) begin
                tgt_reg <= sel_code;
                unique case (op_reg)
                    OP_EVENT: begin
                        nores_reg <= was_shown_reg;
                        time_mem[sel_idx] <= (now_reg != 0) ? now_reg : 32'd1;
                        shown_reg[sel_idx] <= 1'b1;
                        if (was_shown_reg) begin
                            // unlink: patch neighbours, pointers
                            if (valid_code(rd_next_reg))
                                prev_mem[IW'(rd_next_reg - 8'd1)] <= rd_prev_reg;
                            if (valid_code(rd_prev_reg))
                                next_mem[IW'(rd_prev_reg - 8'd1)] <= rd_next_reg;
                            oldest_reg   <= new_old_c;
                            newest_reg   <= new_new_c;
                            nonempty_reg <= new_ne_c;
                        end else begin
                            next_mem[sel_idx] <= 8'd0;
                            if (nonempty_reg && valid_code(newest_reg)) begin
                                prev_mem[sel_idx] <= newest_reg;
                                next_mem[IW'(newest_reg - 8'd1)] <= code_reg;
                            end else begin
                                prev_mem[sel_idx] <= 8'd0;
                                oldest_reg <= code_reg;
                            end
                            newest_reg   <= code_reg;
                            nonempty_reg <= 1'b1;
                        end
                    end
                    OP_TICK: begin
                        nores_reg <= 1'b0;
                        shown_reg[sel_idx] <= 1'b0;
                        if (valid_code(rd_next_reg)) begin
                            prev_mem[IW'(rd_next_reg - 8'd1)] <= 8'd0;
                            oldest_reg <= rd_next_reg;
                        end else begin
                            nonempty_reg <= 1'b0;
                        end
                    end
                    default: begin
                        nores_reg    <= 1'b0;
                        shown_reg    <= '0;
                        nonempty_reg <= 1'b0;
                        oldest_reg   <= 8'd0;
                        newest_reg   <= 8'd0;
                    end
                endcase
            end
            if (cmd.do_relink) begin
                // append the repeated code at the newest end
                next_mem[IW'(code_reg - 8'd1)] <= 8'd0;
                if (nonempty_reg && valid_code(newest_reg)) begin
                    prev_mem[IW'(code_reg - 8'd1)] <= newest_reg;
                    next_mem[IW'(newest_reg - 8'd1)] <= code_reg;
                end else begin
                    prev_mem[IW'(code_reg - 8'd1)] <= 8'd0;
                    oldest_reg <= code_reg;
                end
                newest_reg   <= code_reg;
                nonempty_reg <= 1'b1;
            end
        end
    end

    // geometry, stage 1: row by reciprocal multiply, column by back-multiply
    logic [23:0] row_prod;
    logic [7:0]  col_c, row_c;
    logic [1:0]  nd_c;
    always_comb begin
        row_prod = {16'd0, tgt_reg} * {7'd0, RowRecip};
        row_c = row_prod[23:16];
        col_c = tgt_reg - 8'(row_c * CODES_PER_ROW);
        nd_c  = (tgt_reg < 8'd10) ? 2'd1 : ((tgt_reg < 8'd100) ? 2'd2 : 2'd3);
    end

    logic [15:0] xb_reg, y_reg, w3_reg, clrw_reg, clrh_reg;
    logic [1:0]  nd_reg;
    logic [7:0]  code_o_reg;
    logic [1:0]  kind_reg;
    always_ff @(posedge aclk) begin
        if (cmd.do_geom) begin
            xb_reg   <= 16'(col_c * 3 * cw_reg);
            y_reg    <= 16'(row_c * ch_reg);
            w3_reg   <= 16'(3 * cw_reg);
            clrw_reg <= 16'(CODES_PER_ROW * cw_reg);
            clrh_reg <= 16'(Rows * ch_reg);
            nd_reg   <= nd_c;
            code_o_reg <= tgt_reg;
            kind_reg <= (op_reg == OP_EVENT) ? CMD_DRAW :
                        ((op_reg == OP_TICK) ? CMD_ERASE : CMD_CLEAR);
        end
    end

    function automatic logic [15:0] sat16(input logic [15:0] v, input logic [15:0] m);
        return (v > m) ? m : v;
    endfunction

    logic [15:0] x_c, w_c;
    always_comb begin
        x_c = xb_reg;
        w_c = w3_reg;
        if (nd_reg == 2'd1) begin
            x_c = xb_reg + {10'd0, cw_reg};
            w_c = {10'd0, cw_reg};
        end else if (nd_reg == 2'd2) begin
            x_c = xb_reg + {11'd0, cw_reg[5:1]};
            w_c = {9'd0, cw_reg, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.show_out) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.show_out) begin
            m_command <= kind_reg;
            if (kind_reg == CMD_CLEAR) begin
                m_code        <= 7'd0;
                m_x_pos       <= 10'd0;
                m_y_pos       <= 10'd0;
                m_area_width  <= 9'(sat16(clrw_reg, 16'd511));
                m_area_height <= 10'(sat16(clrh_reg, 16'd1023));
                m_digit_count <= 2'd0;
            end else begin
                m_code        <= code_o_reg[6:0];
                m_x_pos       <= 10'(sat16(x_c, 16'd1023));
                m_y_pos       <= 10'(sat16(y_reg, 16'd1023));
                m_area_width  <= 9'(sat16(w_c, 16'd511));
                m_area_height <= {3'd0, ch_reg};
                m_digit_count <= nd_reg;
            end
        end
    end

    // the geometry step may only start once the previous result is gone
    assign out_busy = m_tvalid && !m_tready;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_list: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_relink |-> op_reg == OP_EVENT) else $error("list state");
    a_tick_oldest: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.do_link && op_reg == OP_TICK) |-> nonempty_reg)
        else $error("expiry on empty list");
endmodule

@@ sv/event_code_activity_display_core.sv @@
// Top level of the event code activity display.
// Depends on ecad_pkg, ecad_ctrl, ecad_dp.
//
// Takes event, tick and clear items and gives at most one draw, erase or
// clear command per item. One item is in work at a time: an item that causes
// a result reaches the result register through the read, link update,
// geometry multiply and output load steps, and the next item is taken only
// once the previous one is through; a repeated event goes through the extra
// relink step and gives no result; ignored items free the input after the link
// step. The geometry step waits while an earlier result is still held by the
// receiver. A tick expires at most the oldest code. Configuration writes are
// always taken.
module event_code_activity_display_core #(
    parameter int NUM_CODES = ecad_pkg::NumCodesDefault,
    parameter int CODES_PER_ROW = ecad_pkg::CodesPerRowDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // event_code[7:0], now_us[39:8]
    input  logic [1:0]  s_tuser,   // operation
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // code[6:0], x_pos[16:7], y_pos[26:17],
                                   // area_width[35:27], area_height[45:36],
                                   // digit_count[47:46]
    output logic [1:0]  m_tuser    // command
);
    import ecad_pkg::*;

    ecad_cmd_t    cmd;
    ecad_status_t status;
    logic         out_busy;

    assign cfg_ready = 1'b1;

    ecad_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .out_busy, .status, .cmd
    );

    ecad_dp #(.NUM_CODES(NUM_CODES), .CODES_PER_ROW(CODES_PER_ROW)) u_dp (
        .aclk, .aresetn, .cmd, .status,
        .in_op(s_tuser), .in_code(s_tdata[7:0]), .in_now(s_tdata[39:8]),
        .cfg_valid, .cfg_index, .cfg_data,
        .out_busy, .m_tvalid, .m_tready,
        .m_command(m_tuser), .m_code(m_tdata[6:0]), .m_x_pos(m_tdata[16:7]),
        .m_y_pos(m_tdata[26:17]), .m_area_width(m_tdata[35:27]),
        .m_area_height(m_tdata[45:36]), .m_digit_count(m_tdata[47:46])
    );
endmodule

@@ test/tb.sv @@
// Testbench for event_code_activity_display_core: random and directed event, tick and
// clear items, checked against a behavioral model of the code list and grid geometry.
// Depends on ecad_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
    import ecad_pkg::*;

    localparam int NCODES = 127;
    localparam int PER_ROW = 10;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_STALL_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  evcode;
        logic [31:0] now;
    } item_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] code;
        logic [9:0] x;
        logic [9:0] y;
        logic [8:0] w;
        logic [9:0] h;
        logic [1:0] nd;
    } gfx_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // event_code, now_us
    logic [1:0]  s_tuser = '0;    // operation
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // code, x_pos, y_pos, area_width, area_height,
                                  // digit_count
    logic [1:0]  m_tuser;         // command

    event_code_activity_display_core dut (.*);

    always #2 aclk = ~aclk;

    // model state
    logic [30:0] hold_us = 31'd700000;
    logic [5:0]  cw = 6'd8;
    logic [6:0]  ch = 7'd16;
    logic        shown [1:NCODES];
    logic [31:0] seen_at [1:NCODES];
    logic [7:0]  nxt [1:NCODES];
    logic [7:0]  prv [1:NCODES];
    logic [7:0]  oldest = 0, newest = 0;
    logic        nonempty = 0;

    item_t    pending_items [$];
    gfx_cmd_t expected_cmds [$];
    int  errors = 0;
    int  cycles = 0;
    bit  stim_done = 0;
    bit  long_stall = 0;
    bit  in_acc = 0;

    function automatic logic [31:0] sat(logic [31:0] v, logic [31:0] mx);
        return v > mx ? mx : v;
    endfunction

    function automatic gfx_cmd_t cell_cmd(logic [1:0] cmd, int c);
        gfx_cmd_t r;
        int nd, x, y, w;
        nd = c < 10 ? 1 : (c < 100 ? 2 : 3);
        x = (c % PER_ROW) * 3 * cw;
        y = (c / PER_ROW) * ch;
        if (nd == 1) begin
            x += cw; w = cw;
        end else if (nd == 2) begin
            x += cw / 2; w = 2 * cw;
        end else begin
            w = 3 * cw;
        end
        r.cmd = cmd; r.code = c[6:0];
        r.x = 10'(sat(x, 1023)); r.y = 10'(sat(y, 1023)); r.w = 9'(sat(w, 511));
        r.h = 10'(sat({25'd0, ch}, 1023)); r.nd = nd[1:0];
        return r;
    endfunction

    task automatic list_remove(int c);
        logic [7:0] p, n;
        p = prv[c]; n = nxt[c];
        if (n != 0) prv[n] = p; else newest = p;
        if (p != 0) nxt[p] = n; else oldest = n;
        if (p == 0 && n == 0) nonempty = 0;
    endtask

    task automatic list_append(int c);
        nxt[c] = 0;
        if (nonempty && newest != 0) begin
            prv[c] = newest; nxt[newest] = c[7:0];
        end else begin
            prv[c] = 0; oldest = c[7:0];
        end
        newest = c[7:0];
        nonempty = 1;
    endtask

    // update the display model for one accepted item and queue its command
    task automatic predict_display(item_t it);
        gfx_cmd_t r;
        logic [31:0] age;
        int c;
        bit was;
        case (it.op)
            OP_EVENT: begin
                c = it.evcode;
                if (c != 0 && c <= NCODES) begin
                    was = shown[c];
                    if (was) list_remove(c);
                    list_append(c);
                    shown[c] = 1;
                    seen_at[c] = it.now != 0 ? it.now : 32'd1;
                    if (!was) expected_cmds.push_back(cell_cmd(CMD_DRAW, c));
                end
            end
            OP_TICK: begin
                c = oldest;
                if (nonempty && c != 0) begin
                    age = it.now - seen_at[c];
                    if (!age[31] && age > {1'b0, hold_us}) begin
                        shown[c] = 0;
                        if (nxt[c] != 0) begin
                            prv[nxt[c]] = 0; oldest = nxt[c];
                        end else begin
                            nonempty = 0;
                        end
                        expected_cmds.push_back(cell_cmd(CMD_ERASE, c));
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 1; i <= NCODES; i++) shown[i] = 0;
                nonempty = 0; oldest = 0; newest = 0;
                r = '0;
                r.cmd = CMD_CLEAR;
                r.w = 9'(sat(PER_ROW * cw, 511));
                r.h = 10'(sat(((NCODES + PER_ROW - 1) / PER_ROW) * ch, 1023));
                expected_cmds.push_back(r);
            end
            default: ;
        endcase
    endtask

    // record acceptance at the rising edge for the driver
    always @(posedge aclk) begin
        in_acc <= aresetn && s_tvalid && s_tready;
    end

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_acc) predict_display(pending_items.pop_front());
            if (s_tvalid && !in_acc) begin
                // hold
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_items[0].op;
                s_tdata <= {pending_items[0].now, pending_items[0].evcode};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off
    int rx_phase = 0;
    int stall_cnt = 0;
    always @(negedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (long_stall && stall_cnt < LONG_STALL_CYCLES) begin
            stall_cnt <= stall_cnt + 1;
            m_tready <= 1'b0;
        end else if (rx_phase % 400 < 120) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 2) != 0);
    end

    // monitor
    always @(posedge aclk) begin
        gfx_cmd_t got, exp_c;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.cmd  = m_tuser;
            got.code = m_tdata[6:0];
            got.x    = m_tdata[16:7];
            got.y    = m_tdata[26:17];
            got.w    = m_tdata[35:27];
            got.h    = m_tdata[45:36];
            got.nd   = m_tdata[47:46];
            if (expected_cmds.size() == 0) begin
                $error("unexpected result: command %0d code %0d", got.cmd, got.code);
                errors <= errors + 1;
            end else begin
                exp_c = expected_cmds.pop_front();
                if (got.cmd != exp_c.cmd) $error("command: exp %0d got %0d", exp_c.cmd, got.cmd);
                if (got.code != exp_c.code) $error("code: exp %0d got %0d", exp_c.code, got.code);
                if (got.x != exp_c.x) $error("x_pos: exp %0d got %0d", exp_c.x, got.x);
                if (got.y != exp_c.y) $error("y_pos: exp %0d got %0d", exp_c.y, got.y);
                if (got.w != exp_c.w) $error("area_width: exp %0d got %0d", exp_c.w, got.w);
                if (got.h != exp_c.h) $error("area_height: exp %0d got %0d", exp_c.h, got.h);
                if (got.nd != exp_c.nd) $error("digit_count: exp %0d got %0d", exp_c.nd, got.nd);
                if (got != exp_c) errors <= errors + 1;
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_item(logic [1:0] op, logic [7:0] c, logic [31:0] t);
        item_t it;
        it.op = op; it.evcode = c; it.now = t;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_cmds.size() > 0)
            @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HOLD:    hold_us = val[30:0];
            REG_CWIDTH:  cw = val[5:0];
            REG_CHEIGHT: ch = val[6:0];
            default: ;
        endcase
    endtask

    // mostly well-formed: events and ticks with rising time, mixed at random
    task automatic random_phase(int n, logic [31:0] span);
        logic [31:0] t;
        int k;
        t = $urandom;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            t += $urandom_range(0, span);
            if (k < 50) add_item(OP_EVENT, 8'($urandom_range(1, 20) + (k < 10 ? 100 : 0)), t);
            else if (k < 88) add_item(OP_TICK, 8'($urandom), t);
            else if (k < 91) add_item(OP_CLEAR, 8'($urandom), $urandom);
            else if (k < 94) add_item(2'd3, 8'($urandom), $urandom);
            else if (k < 97) add_item(OP_EVENT, (k & 1) ? 8'd0 : 8'($urandom_range(128, 255)),
                                      $urandom);
            else add_item(OP_TICK, 8'($urandom), $urandom);
        end
    endtask

    initial begin
        for (int i = 1; i <= NCODES; i++) begin
            shown[i] = 0; seen_at[i] = 0; nxt[i] = 0; prv[i] = 0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every operation, time zero, repeats, ignored codes
        add_item(OP_EVENT, 8'd1, 32'd0);
        add_item(OP_EVENT, 8'd9, 32'd5);
        add_item(OP_EVENT, 8'd10, 32'd6);
        add_item(OP_EVENT, 8'd99, 32'd7);
        add_item(OP_EVENT, 8'd100, 32'd8);
        add_item(OP_EVENT, 8'd127, 32'hFFFF_FFFF);
        add_item(OP_EVENT, 8'd1, 32'd10);
        add_item(OP_EVENT, 8'd0, 32'd10);
        add_item(OP_EVENT, 8'd128, 32'd10);
        add_item(OP_EVENT, 8'd255, 32'd10);
        add_item(2'd3, 8'hFF, 32'hFFFF_FFFF);
        add_item(OP_TICK, 8'd0, 32'd700000);
        add_item(OP_TICK, 8'd0, 32'd700006);
        add_item(OP_TICK, 8'd0, 32'h8000_0010);
        add_item(OP_TICK, 8'd0, 32'd800000);
        add_item(OP_TICK, 8'd0, 32'd800000);
        add_item(OP_CLEAR, 8'd0, 32'd0);
        add_item(OP_TICK, 8'd0, 32'd900000);
        drain();

        // extreme geometry and hold times
        write_reg(REG_HOLD, 32'hFFFF_FFFF);
        write_reg(REG_CWIDTH, 32'd32);
        write_reg(REG_CHEIGHT, 32'd64);
        add_item(OP_EVENT, 8'd127, 32'd1);
        add_item(OP_EVENT, 8'd9, 32'd1);
        add_item(OP_EVENT, 8'd55, 32'd1);
        add_item(OP_TICK, 8'd0, 32'h7FFF_FFFF);
        add_item(OP_CLEAR, 8'd0, 32'd0);
        drain();
        write_reg(REG_HOLD, 32'd0);
        write_reg(REG_CWIDTH, 32'd1);
        write_reg(REG_CHEIGHT, 32'd1);
        add_item(OP_EVENT, 8'd3, 32'd100);
        add_item(OP_TICK, 8'd0, 32'd100);
        add_item(OP_TICK, 8'd0, 32'd101);
        drain();

        // random phases over several settings
        write_reg(REG_HOLD, 32'd50);
        write_reg(REG_CWIDTH, $urandom_range(1, 32));
        write_reg(REG_CHEIGHT, $urandom_range(1, 64));
        random_phase(200, 20);
        drain();

        // long receiver hold-off while the sender keeps offering
        write_reg(REG_HOLD, 32'd700000);
        write_reg(REG_CWIDTH, 32'd8);
        write_reg(REG_CHEIGHT, 32'd16);
        @(negedge aclk);
        long_stall = 1;
        random_phase(200, 40000);
        drain();

        write_reg(REG_HOLD, $urandom_range(0, 200));
        write_reg(REG_CWIDTH, $urandom_range(1, 32));
        write_reg(REG_CHEIGHT, $urandom_range(1, 64));
        random_phase(200, 60);
        drain();
        repeat (20) @(negedge aclk);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
